### hdl/diamond_square_heightmap_top_assert.svh
// assertion macros shared by the block's checking code
`ifndef DIAMOND_SQUARE_HEIGHTMAP_TOP_ASSERT_SVH
`define DIAMOND_SQUARE_HEIGHTMAP_TOP_ASSERT_SVH

// same-cycle implication
`define DSH_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/dsh_pkg.sv
package dsh_pkg;

  localparam logic [2:0] MAX_SIZE_EXP = 3'd6;
  localparam int STORE_DEPTH = 4225;
  localparam int AW = 13;
  localparam int CW = 7;
  localparam int HW = 16;

  // floor(u/3) = (u * DIV3_MUL) >> 20 for u < 2^19
  localparam logic [18:0] DIV3_MUL = 19'd349526;
  localparam logic [18:0] DIV3_BIAS = 19'd98304;

  localparam logic [1:0] REG_SIZE_EXP = 2'd0;
  localparam logic [1:0] REG_WRAP = 2'd1;
  localparam logic [1:0] REG_FEAT_LOG = 2'd2;

  typedef enum logic [3:0] {
    PH_CORNER  = 4'b0001,
    PH_DIAMOND = 4'b0010,
    PH_SQ_ROWS = 4'b0100,
    PH_SQ_COLS = 4'b1000
  } phase_t;

  typedef struct packed {
    logic                   start;
    logic                   corner;
    logic                   done;
    logic                   cnt3;
    logic [CW-1:0]          x;
    logic [CW-1:0]          y;
    logic [AW-1:0]          addr;
    logic [3:0][AW-1:0]     nb_addr;
    logic [3:0]             nb_valid;
    logic [2:0]             shift;
    logic signed [HW-1:0]   noise;
  } job_t;

  typedef struct packed {
    logic busy;
    logic clearing;
    logic loading;
  } back_status_t;

endpackage

### hdl/dsh_front.sv
module dsh_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [2:0]           size_exponent,
  input  logic                 wrap_mode,
  input  logic [2:0]           feature_ratio_log,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [15:0]   noise,
  input  logic                 full,
  output logic                 push,
  output dsh_pkg::job_t        job
);
  import dsh_pkg::*;

  logic         map_active;
  logic         act_wrap;
  logic [2:0]   act_e;
  logic [6:0]   act_side;
  logic [6:0]   level_step;
  logic [2:0]   level_index;
  phase_t       phase;
  logic [6:0]   cursor_x;
  logic [6:0]   cursor_y;

  logic [2:0]   s_e;
  logic [6:0]   s_side;
  logic [6:0]   s_step;
  logic         c_wrap;
  logic [2:0]   c_e;
  logic [6:0]   c_side;
  logic [6:0]   c_step;
  logic [2:0]   c_li;
  phase_t       c_phase;
  logic [6:0]   c_cx;
  logic [6:0]   c_cy;
  logic [6:0]   hs;
  logic [6:0]   px;
  logic [6:0]   py;
  logic [3:0][8:0] dx;
  logic [3:0][8:0] dy;
  logic [3:0]   nbv;
  logic [3:0][AW-1:0] nba;

  logic         done;
  phase_t       n_phase;
  logic [6:0]   n_cx;
  logic [6:0]   n_cy;
  logic [6:0]   n_step;
  logic [2:0]   n_li;

  function automatic logic [AW-1:0] grid_addr(input logic [6:0] gx, input logic [6:0] gy,
                                              input logic [2:0] e, input logic w);
    grid_addr = (AW'(gy) << e) + (w ? AW'(0) : AW'(gy)) + AW'(gx);
  endfunction

  // settings latched at map start
  always_comb begin
    if (size_exponent == 3'd0) begin
      s_e = 3'd1;
    end else if (size_exponent > MAX_SIZE_EXP) begin
      s_e = MAX_SIZE_EXP;
    end else begin
      s_e = size_exponent;
    end
    if (wrap_mode) begin
      s_side = 7'd1 << s_e;
      s_step = (feature_ratio_log > s_e) ? 7'd0 : ((7'd1 << s_e) >> feature_ratio_log);
    end else begin
      s_side = (7'd1 << s_e) + 7'd1;
      s_step = 7'd1 << s_e;
    end
    c_wrap  = map_active ? act_wrap : wrap_mode;
    c_e     = map_active ? act_e : s_e;
    c_side  = map_active ? act_side : s_side;
    c_step  = map_active ? level_step : s_step;
    c_li    = map_active ? level_index : 3'd0;
    c_phase = map_active ? phase : PH_CORNER;
    c_cx    = map_active ? cursor_x : 7'd0;
    c_cy    = map_active ? cursor_y : 7'd0;
    hs      = c_step >> 1;
  end

  // point coordinates and neighbour addresses
  always_comb begin
    logic [8:0] hp;
    logic [8:0] hn;
    logic [8:0] nx;
    logic [8:0] ny;
    logic [6:0] m;
    hp = {2'b00, hs};
    hn = ~hp + 9'd1;
    m  = c_side - 7'd1;
    if (c_phase == PH_CORNER) begin
      if (c_wrap) begin
        px = (c_cx[0] ? c_step : 7'd0) & m;
        py = (c_cx[1] ? c_step : 7'd0) & m;
      end else begin
        px = c_cx[1] ? m : 7'd0;
        py = c_cx[0] ? m : 7'd0;
      end
    end else begin
      px = c_cx;
      py = c_cy;
    end
    if (c_phase == PH_DIAMOND) begin
      dx = {hp, hn, hp, hn};
      dy = {hp, hp, hn, hn};
    end else begin
      dx = {9'd0, 9'd0, hp, hn};
      dy = {hp, hn, 9'd0, 9'd0};
    end
    for (int i = 0; i < 4; i++) begin
      nx = {2'b00, px} + dx[i];
      ny = {2'b00, py} + dy[i];
      if (c_wrap) begin
        nbv[i] = 1'b1;
        nba[i] = grid_addr(nx[6:0] & m, ny[6:0] & m, c_e, 1'b1);
      end else begin
        nbv[i] = !nx[8] && (nx[7:0] < {1'b0, c_side}) && !ny[8] && (ny[7:0] < {1'b0, c_side});
        nba[i] = grid_addr(nx[6:0], ny[6:0], c_e, 1'b0);
      end
    end
  end

  // visiting order
  always_comb begin
    logic [7:0] ncx;
    logic [7:0] ncy;
    logic [6:0] nst;
    done    = 1'b0;
    n_phase = c_phase;
    n_cx    = c_cx;
    n_cy    = c_cy;
    n_step  = c_step;
    n_li    = c_li;
    ncx     = {1'b0, c_cx} + {1'b0, c_step};
    ncy     = {1'b0, c_cy} + {1'b0, c_step};
    nst     = c_step >> 1;
    case (c_phase)
      PH_CORNER: begin
        if (c_cx[1:0] != 2'd3) begin
          n_cx = c_cx + 7'd1;
        end else if (c_step <= 7'd1) begin
          done = 1'b1;
        end else begin
          n_phase = PH_DIAMOND;
          n_cx = hs;
          n_cy = hs;
        end
      end
      default: begin
        if (ncx < {1'b0, c_side}) begin
          n_cx = ncx[6:0];
        end else begin
          n_cx = (c_phase == PH_SQ_COLS) ? 7'd0 : hs;
          if (ncy < {1'b0, c_side}) begin
            n_cy = ncy[6:0];
          end else if (c_phase == PH_SQ_COLS) begin
            n_step = nst;
            n_li = c_li + 3'd1;
            if (nst <= 7'd1) begin
              done = 1'b1;
            end else begin
              n_phase = PH_DIAMOND;
              n_cx = nst >> 1;
              n_cy = nst >> 1;
            end
          end else if (c_phase == PH_DIAMOND) begin
            n_phase = PH_SQ_ROWS;
            n_cx = hs;
            n_cy = 7'd0;
          end else begin
            n_phase = PH_SQ_COLS;
            n_cx = 7'd0;
            n_cy = hs;
          end
        end
      end
    endcase
  end

  assign in_stall = full;
  assign push = in_valid && !full;

  always_comb begin
    job.start    = !map_active;
    job.corner   = (c_phase == PH_CORNER);
    job.done     = done;
    job.cnt3     = (nbv != 4'hF);
    job.x        = px;
    job.y        = py;
    job.addr     = grid_addr(px, py, c_e, c_wrap);
    job.nb_addr  = nba;
    job.nb_valid = (c_phase == PH_CORNER) ? 4'h0 : nbv;
    job.shift    = c_li;
    job.noise    = noise;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_active  <= 1'b0;
      act_wrap    <= 1'b0;
      act_e       <= MAX_SIZE_EXP;
      act_side    <= (7'd1 << MAX_SIZE_EXP) + 7'd1;
      level_step  <= 7'd1 << MAX_SIZE_EXP;
      level_index <= 3'd0;
      phase       <= PH_CORNER;
      cursor_x    <= 7'd0;
      cursor_y    <= 7'd0;
    end else if (push) begin
      map_active  <= !done;
      act_wrap    <= c_wrap;
      act_e       <= c_e;
      act_side    <= c_side;
      level_step  <= n_step;
      level_index <= n_li;
      phase       <= n_phase;
      cursor_x    <= n_cx;
      cursor_y    <= n_cy;
    end
  end

endmodule

### hdl/dsh_queue.sv
module dsh_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dsh_pkg::job_t  push_job,
  output logic           full,
  input  logic           pop,
  output dsh_pkg::job_t  pop_job,
  output logic           empty
);
  import dsh_pkg::*;

  job_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign pop_job = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

### hdl/dsh_back.sv
module dsh_back (
  input  logic                   clk,
  input  logic                   rst,
  input  dsh_pkg::job_t          q_job,
  input  logic                   q_empty,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [6:0]             point_x,
  output logic [6:0]             point_y,
  output logic signed [15:0]     height,
  output logic                   map_done,
  output dsh_pkg::back_status_t  status
);
  import dsh_pkg::*;

  typedef enum logic [5:0] {
    B_IDLE  = 6'b000001,
    B_CLEAR = 6'b000010,
    B_READ  = 6'b000100,
    B_LAST  = 6'b001000,
    B_DIV   = 6'b010000,
    B_OUT   = 6'b100000
  } bstate_t;

  logic [HW-1:0]        store [STORE_DEPTH];
  logic [HW-1:0]        rdata;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [HW-1:0]        mem_wdata;
  logic [AW-1:0]        mem_raddr;

  bstate_t              state;
  job_t                 cur;
  logic [AW-1:0]        clr_cnt;
  logic [1:0]           idx;
  logic                 acc_en;
  logic                 acc_v;
  logic signed [17:0]   sum;
  logic [36:0]          prod;
  logic signed [17:0]   quarter;
  logic signed [17:0]   mean;
  logic signed [15:0]   nsh;
  logic signed [17:0]   tot;
  logic signed [15:0]   h;
  logic                 load;
  logic [18:0]          u;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    rdata <= store[mem_raddr];
  end

  assign mem_raddr = cur.nb_addr[idx];
  assign u = {sum[17], sum} + DIV3_BIAS;

  always_comb begin
    mean = cur.cnt3 ? ($signed({1'b0, prod[36:20]}) - 18'sd32768) : quarter;
    nsh  = cur.noise >>> cur.shift;
    tot  = mean + 18'(nsh);
    if (cur.corner) begin
      h = cur.noise;
    end else if (tot > 18'sd32767) begin
      h = 16'sh7FFF;
    end else if (tot < -18'sd32768) begin
      h = -16'sh8000;
    end else begin
      h = tot[15:0];
    end
  end

  assign load  = (state == B_OUT) && (!out_valid || !out_stall);
  assign q_pop = (state == B_IDLE) && !q_empty;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur.addr;
    mem_wdata = h;
    if (state == B_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else if (load) begin
      mem_we = 1'b1;
    end
  end

  assign status.busy     = (state != B_IDLE);
  assign status.clearing = (state == B_CLEAR);
  assign status.loading  = load;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_job;
    end
    if (state == B_DIV) begin
      prod    <= {19'd0, u[17:0]} * {18'd0, DIV3_MUL};
      quarter <= sum >>> 2;
    end
    if (state == B_IDLE) begin
      sum <= '0;
    end else if ((state == B_READ || state == B_LAST) && acc_en && acc_v) begin
      sum <= sum + 18'($signed(rdata));
    end
    if (load) begin
      point_x  <= cur.x;
      point_y  <= cur.y;
      height   <= h;
      map_done <= cur.done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      clr_cnt   <= '0;
      idx       <= 2'd0;
      acc_en    <= 1'b0;
      acc_v     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          idx     <= 2'd0;
          acc_en  <= 1'b0;
          clr_cnt <= '0;
          if (!q_empty) begin
            if (q_job.start) begin
              state <= B_CLEAR;
            end else if (q_job.corner) begin
              state <= B_OUT;
            end else begin
              state <= B_READ;
            end
          end
        end
        B_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(STORE_DEPTH - 1)) begin
            state <= cur.corner ? B_OUT : B_READ;
          end
        end
        B_READ: begin
          acc_en <= 1'b1;
          acc_v  <= cur.nb_valid[idx];
          idx    <= idx + 2'd1;
          if (idx == 2'd3) begin
            state <= B_LAST;
          end
        end
        B_LAST: begin
          acc_en <= 1'b0;
          state  <= B_DIV;
        end
        B_DIV: begin
          state <= B_OUT;
        end
        B_OUT: begin
          if (load) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/diamond_square_heightmap_top.sv
// diamond-square height generator, one output transaction per noise transaction
// path from input accept to output valid: queue pop, then for points other than corners
//   4 store reads through the single read port and a divide step, then the output register
// the queue lets the front end take new noise while the back end is busy; the first
//   point of each map adds a clearing pass over all 4225 entries of the height store
// reset: synchronous active-high rst clears control state and loads the register
//   defaults (size_exponent 6, wrap_mode 0, feature_ratio_log 1)
module diamond_square_heightmap_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  noise,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [6:0]          point_x,
  output logic [6:0]          point_y,
  output logic signed [15:0]  height,
  output logic                map_done
);
  import dsh_pkg::*;

  `include "diamond_square_heightmap_top_assert.svh"

  // configuration registers, latched by the front end at each map start
  logic [2:0]   size_exponent;
  logic         wrap_mode;
  logic [2:0]   feature_ratio_log;

  logic         q_push;
  logic         q_full;
  logic         q_pop;
  logic         q_empty;
  job_t         f_job;
  job_t         q_job;
  back_status_t bk_status;

  assign pready = 1'b1;

  // register write on the access phase of an apb transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      size_exponent     <= 3'd6;
      wrap_mode         <= 1'b0;
      feature_ratio_log <= 3'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_SIZE_EXP: size_exponent     <= pwdata[2:0];
        REG_WRAP:     wrap_mode         <= pwdata[0];
        REG_FEAT_LOG: feature_ratio_log <= pwdata[2:0];
        default:      ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      REG_SIZE_EXP: prdata = {29'd0, size_exponent};
      REG_WRAP:     prdata = {31'd0, wrap_mode};
      REG_FEAT_LOG: prdata = {29'd0, feature_ratio_log};
      default:      prdata = 32'd0;
    endcase
  end

  // front end: walks the visiting order and builds the neighbour address list
  dsh_front u_front (
    .clk               (clk),
    .rst               (rst),
    .size_exponent     (size_exponent),
    .wrap_mode         (wrap_mode),
    .feature_ratio_log (feature_ratio_log),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .noise             (noise),
    .full              (q_full),
    .push              (q_push),
    .job               (f_job)
  );

  // two-entry queue decouples the address walk from the store accesses
  dsh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (f_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_job),
    .empty    (q_empty)
  );

  // back end: height store, neighbour mean, noise add, output register
  dsh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_job     (q_job),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .point_x   (point_x),
    .point_y   (point_y),
    .height    (height),
    .map_done  (map_done),
    .status    (bk_status)
  );

  // an accepted transaction is held by the queue or the back end next cycle
  `DSH_ASSERT_NEXT(a_accept_held, in_valid && !in_stall, !q_empty || bk_status.busy, "transaction lost after accept")
  // no result leaves while the store is being cleared
  `DSH_ASSERT_IMPL(a_no_load_in_clear, bk_status.clearing, !bk_status.loading, "output load during clear")
  // the back end only takes work when it is idle
  `DSH_ASSERT_IMPL(a_pop_when_idle, q_pop, !bk_status.busy && !q_empty, "queue pop while busy")

endmodule
